FILE: rtl/core/rc4mx_pkg.sv
// ---------------------------------------------------------------------------
// rc4mx_pkg - shared types and constants for the RC4 mixing engine
// Box and key store geometry, command codes, sequencer state encoding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc4mx_pkg;

    localparam int BOX_SIZE = 256;
    localparam int BOX_AW   = $clog2(BOX_SIZE);
    localparam int KEY_MAX  = 128;
    localparam int KEY_IW   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_CW   = $clog2(KEY_MAX + 1);

    typedef enum logic [2:0] {
        CMD_KEY   = 3'd0,
        CMD_SCHED = 3'd1,
        CMD_MIX   = 3'd2,
        CMD_SWAP  = 3'd3,
        CMD_DATA  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        OP_SWAP,
        OP_SCHED,
        OP_DATA
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_RD_T,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/rc4_cipher_with_extra_mixing_unit.sv
// ---------------------------------------------------------------------------
// rc4_cipher_with_extra_mixing_unit - RC4 engine with box mixing commands
// Key loading into a key store; key schedule, accumulating mix swap, direct swap and data
// encryption, all built on one sequenced swap unit around the box memory.
// ---------------------------------------------------------------------------
//  channel | signals                       | beat
//  --------+-------------------------------+-------------------------------
//  in      | in_valid in_stall             | cmd, value, position
//  out     | out_valid out_stall           | out_byte
//
//  Key bytes and unused codes are taken without leaving idle. Direct swap and mix
//  run one swap; data runs a swap, a keystream read and an emit that waits for the
//  output register; the key schedule runs 256 swaps. A swap is two reads and two
//  writes through the single read port of the box memory, one access per cycle.
//  No clearing pass after reset: per-entry valid bits give the identity box.
//  A finished byte waits in the output register while the next beat enters.
`timescale 1ns / 1ps
`default_nettype none

module rc4_cipher_with_extra_mixing_unit
    import rc4mx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  value,
    input  wire logic [7:0]  position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte
);

    // box memory and its valid bits
    logic [7:0]            box_mem [BOX_SIZE];
    logic [BOX_SIZE-1:0]   box_vld_reg;
    logic [7:0]            box_rdata_reg;
    logic [BOX_AW-1:0]     rd_addr_reg;
    logic                  rd_valid_reg;
    logic                  box_re;
    logic [BOX_AW-1:0]     box_raddr;
    logic                  box_we;
    logic [BOX_AW-1:0]     box_waddr;
    logic [7:0]            box_wdata;
    logic                  box_clr;
    logic [7:0]            box_val;

    // key store
    logic [7:0]            key_mem [KEY_MAX];
    logic [7:0]            key_rdata_reg;
    logic                  key_we;
    logic                  key_re;

    // sequencer state
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [BOX_AW-1:0]     a_reg, a_next;
    logic [BOX_AW-1:0]     b_reg, b_next;
    logic [7:0]            sa_reg, sa_next;
    logic [7:0]            sb_reg, sb_next;
    logic [7:0]            value_reg, value_next;
    logic [7:0]            stream_i_reg, stream_i_next;
    logic [7:0]            stream_j_reg, stream_j_next;
    logic [7:0]            mix_step_reg, mix_step_next;
    logic [7:0]            mix_acc_reg, mix_acc_next;
    logic [KEY_CW-1:0]     key_count_reg, key_count_next;
    logic [KEY_IW-1:0]     kidx_reg, kidx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic [7:0]            kbyte;
    logic [BOX_AW-1:0]     b_sel;
    logic [7:0]            acc_sum;

    assign box_val  = rd_valid_reg ? box_rdata_reg : 8'(rd_addr_reg);
    assign kbyte    = (key_count_reg == '0) ? 8'd0 : key_rdata_reg;
    assign acc_sum  = 8'(mix_acc_reg + value);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            box_mem[box_waddr] <= box_wdata;
        end
        if (box_re)
        begin
            box_rdata_reg <= box_mem[box_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_count_reg[KEY_IW-1:0]] <= value;
        end
        if (key_re)
        begin
            key_rdata_reg <= key_mem[kidx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_vld_reg  <= '0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (box_clr)
            begin
                box_vld_reg <= '0;
            end
            else if (box_we)
            begin
                box_vld_reg[box_waddr] <= 1'b1;
            end
            if (box_re)
            begin
                rd_addr_reg  <= box_raddr;
                rd_valid_reg <= box_vld_reg[box_raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SWAP;
            stream_i_reg  <= '0;
            stream_j_reg  <= '0;
            mix_step_reg  <= '0;
            mix_acc_reg   <= '0;
            key_count_reg <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            stream_i_reg  <= stream_i_next;
            stream_j_reg  <= stream_j_next;
            mix_step_reg  <= mix_step_next;
            mix_acc_reg   <= mix_acc_next;
            key_count_reg <= key_count_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        value_reg    <= value_next;
        out_byte_reg <= out_byte_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        value_next     = value_reg;
        stream_i_next  = stream_i_reg;
        stream_j_next  = stream_j_reg;
        mix_step_next  = mix_step_reg;
        mix_acc_next   = mix_acc_reg;
        key_count_next = key_count_reg;
        kidx_next      = kidx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        box_re         = 1'b0;
        box_raddr      = a_reg;
        box_we         = 1'b0;
        box_waddr      = a_reg;
        box_wdata      = box_val;
        box_clr        = 1'b0;
        key_we         = 1'b0;
        key_re         = 1'b0;
        b_sel          = b_reg;

        // drop the output beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = value;
                    case (cmd_t'(cmd))
                        CMD_KEY:
                        begin
                            if (key_count_reg < KEY_CW'(KEY_MAX))
                            begin
                                key_we         = 1'b1;
                                key_count_next = key_count_reg + 1'b1;
                            end
                        end
                        CMD_SCHED:
                        begin
                            box_clr       = 1'b1;
                            op_next       = OP_SCHED;
                            a_next        = '0;
                            stream_j_next = '0;
                            kidx_next     = '0;
                            state_next    = ST_RD_A;
                        end
                        CMD_MIX:
                        begin
                            a_next        = BOX_AW'(mix_step_reg + 8'd1);
                            b_next        = BOX_AW'(acc_sum);
                            mix_acc_next  = acc_sum;
                            mix_step_next = 8'(mix_step_reg + 8'd1);
                            op_next       = OP_SWAP;
                            state_next    = ST_RD_A;
                        end
                        CMD_SWAP:
                        begin
                            a_next     = BOX_AW'(position);
                            b_next     = BOX_AW'(value);
                            op_next    = OP_SWAP;
                            state_next = ST_RD_A;
                        end
                        CMD_DATA:
                        begin
                            stream_i_next = 8'(stream_i_reg + 8'd1);
                            a_next        = BOX_AW'(stream_i_reg + 8'd1);
                            op_next       = OP_DATA;
                            state_next    = ST_RD_A;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_A:
            begin
                box_re     = 1'b1;
                box_raddr  = a_reg;
                key_re     = (op_reg == OP_SCHED);
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                sa_next = box_val;
                case (op_reg)
                    OP_DATA:
                    begin
                        b_sel         = BOX_AW'(stream_j_reg + box_val);
                        stream_j_next = 8'(b_sel);
                    end
                    OP_SCHED:
                    begin
                        b_sel         = BOX_AW'(stream_j_reg + box_val + kbyte);
                        stream_j_next = 8'(b_sel);
                    end
                    default:
                    begin
                        b_sel = b_reg;
                    end
                endcase
                b_next     = b_sel;
                box_re     = 1'b1;
                box_raddr  = b_sel;
                state_next = ST_WR_A;
            end
            ST_WR_A:
            begin
                box_we     = 1'b1;
                box_waddr  = a_reg;
                box_wdata  = box_val;
                sb_next    = box_val;
                state_next = ST_WR_B;
            end
            ST_WR_B:
            begin
                box_we    = 1'b1;
                box_waddr = b_reg;
                box_wdata = sa_reg;
                case (op_reg)
                    OP_DATA:
                    begin
                        state_next = ST_RD_T;
                    end
                    OP_SCHED:
                    begin
                        if (a_reg == BOX_AW'(BOX_SIZE - 1))
                        begin
                            stream_i_next = '0;
                            stream_j_next = '0;
                            mix_step_next = '0;
                            mix_acc_next  = '0;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            a_next = a_reg + 1'b1;
                            // wrap the key index at the stored key length
                            if ((KEY_CW'(kidx_reg) + 1'b1) == key_count_reg)
                            begin
                                kidx_next = '0;
                            end
                            else
                            begin
                                kidx_next = kidx_reg + 1'b1;
                            end
                            state_next = ST_RD_A;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_T:
            begin
                box_re     = 1'b1;
                box_raddr  = BOX_AW'(sa_reg + sb_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = value_reg ^ box_val;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("output beat raised outside emit");

    a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_CW'(KEY_MAX))
        else $error("key count beyond store depth");

    a_sched_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR_B && op_reg == OP_SCHED && a_reg == BOX_AW'(BOX_SIZE - 1))
        |=> (stream_i_reg == '0 && stream_j_reg == '0 && mix_step_reg == '0
             && mix_acc_reg == '0 && state_reg == ST_IDLE))
        else $error("key schedule end did not clear counters");
`endif

endmodule

`default_nettype wire
